FILE: src/morse_code_keyer_unit_defines.svh
// assertion macros for the morse code keyer unit
// expects signals named clk and rst in the module that uses them
`ifndef MORSE_CODE_KEYER_UNIT_DEFINES_SVH
`define MORSE_CODE_KEYER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define MCKU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MCKU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define MCKU_ASSERT(lbl, prop, msg)
`define MCKU_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

FILE: src/mck_pkg.sv
// shared types, constants and the character classifier for the morse keyer
// used by every module of the block; no dependencies
package mck_pkg;

  localparam int DUR_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int ELEM_W      = 3;
  localparam int PAT_W       = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DOT_ON      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_ON     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_GAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP    = 3'd4;

  localparam logic [DUR_W-1:0] DOT_ON_RESET      = 16'd200;
  localparam logic [DUR_W-1:0] DASH_ON_RESET     = 16'd600;
  localparam logic [DUR_W-1:0] ELEMENT_GAP_RESET = 16'd200;
  localparam logic [DUR_W-1:0] LETTER_GAP_RESET  = 16'd600;
  localparam logic [DUR_W-1:0] WORD_GAP_RESET    = 16'd1400;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_SPACE,
    KIND_OTHER
  } kind_t;

  // pattern bit i set means element i is a dash
  typedef struct packed {
    logic [ELEM_W-1:0] len;
    logic [PAT_W-1:0]  pattern;
  } morse_t;

  typedef struct packed {
    kind_t  kind;
    morse_t code;
  } desc_t;

  typedef struct packed {
    logic [DUR_W-1:0] dot_on;
    logic [DUR_W-1:0] dash_on;
    logic [DUR_W-1:0] element_gap;
    logic [DUR_W-1:0] letter_gap;
    logic [DUR_W-1:0] word_gap;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ON,
    BK_GAP,
    BK_LETTER,
    BK_WORD
  } back_state_t;

  localparam morse_t LETTER_CODES [26] = '{
    '{3'd2, 5'd2},  '{3'd4, 5'd1},  '{3'd4, 5'd5},  '{3'd3, 5'd1},
    '{3'd1, 5'd0},  '{3'd4, 5'd4},  '{3'd3, 5'd3},  '{3'd4, 5'd0},
    '{3'd2, 5'd0},  '{3'd4, 5'd14}, '{3'd3, 5'd5},  '{3'd4, 5'd2},
    '{3'd2, 5'd3},  '{3'd2, 5'd1},  '{3'd3, 5'd7},  '{3'd4, 5'd6},
    '{3'd4, 5'd11}, '{3'd3, 5'd2},  '{3'd3, 5'd0},  '{3'd1, 5'd1},
    '{3'd3, 5'd4},  '{3'd4, 5'd8},  '{3'd3, 5'd6},  '{3'd4, 5'd9},
    '{3'd4, 5'd13}, '{3'd4, 5'd3}
  };

  localparam morse_t DIGIT_CODES [10] = '{
    '{3'd5, 5'd31}, '{3'd5, 5'd30}, '{3'd5, 5'd28}, '{3'd5, 5'd24},
    '{3'd5, 5'd16}, '{3'd5, 5'd0},  '{3'd5, 5'd1},  '{3'd5, 5'd3},
    '{3'd5, 5'd7},  '{3'd5, 5'd15}
  };

  function automatic desc_t classify(input logic [7:0] c);
    desc_t      d;
    logic [7:0] off;
    d.kind = KIND_OTHER;
    d.code = '0;
    off    = '0;
    if (c == CHAR_SPACE) begin
      d.kind = KIND_SPACE;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      off    = c - CHAR_UPPER_A;
      d.kind = KIND_CHAR;
      d.code = LETTER_CODES[off[4:0]];
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      off    = c - CHAR_LOWER_A;
      d.kind = KIND_CHAR;
      d.code = LETTER_CODES[off[4:0]];
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      off    = c - CHAR_DIGIT_0;
      d.kind = KIND_CHAR;
      d.code = DIGIT_CODES[off[3:0]];
    end
    return d;
  endfunction

endpackage

FILE: src/mck_front.sv
// front end: takes character transfers and turns them into element descriptors
// depends on mck_pkg
module mck_front import mck_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  output logic       push,
  output desc_t      push_data,
  input  logic       push_ready
);

  logic  stage_valid;
  desc_t stage_data;

  assign in_ready  = !stage_valid || push_ready;
  assign push      = stage_valid;
  assign push_data = stage_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_data <= classify(char_code);
    end
  end

endmodule

FILE: src/mck_queue.sv
// short descriptor queue between the front end and the segment sequencer
// depends on mck_pkg
module mck_queue import mck_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  output logic  push_ready,
  input  logic  pop,
  output logic  pop_valid,
  output desc_t pop_data
);

  desc_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [QUEUE_PTR_W-1:0] bump(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: src/mck_back.sv
// segment sequencer: walks one descriptor at a time and drives the output register
// depends on mck_pkg and the assertion macros header
`include "morse_code_keyer_unit_defines.svh"

module mck_back import mck_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_regs_t        cfg,
  input  logic             q_valid,
  input  desc_t            q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             led_level,
  output logic [DUR_W-1:0] duration_ms,
  output logic             last_segment
);

  back_state_t       state, state_next;
  desc_t             cur, cur_next;
  logic [ELEM_W-1:0] elem, elem_next;
  logic              load;
  logic              fetch;
  logic              seg_load;
  logic              seg_level;
  logic [DUR_W-1:0]  seg_dur;
  logic              seg_last;

  assign load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (seg_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur  <= cur_next;
    elem <= elem_next;
    if (seg_load) begin
      led_level    <= seg_level;
      duration_ms  <= seg_dur;
      last_segment <= seg_last;
    end
  end

  always_comb begin
    state_next = state;
    cur_next   = cur;
    elem_next  = elem;
    q_pop      = 1'b0;
    fetch      = 1'b0;
    seg_load   = 1'b0;
    seg_level  = 1'b0;
    seg_dur    = cfg.letter_gap;
    seg_last   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        fetch = 1'b1;
      end
      BK_ON: begin
        if (load) begin
          seg_load   = 1'b1;
          seg_level  = 1'b1;
          seg_dur    = cur.code.pattern[elem] ? cfg.dash_on : cfg.dot_on;
          state_next = BK_GAP;
        end
      end
      BK_GAP: begin
        if (load) begin
          seg_load = 1'b1;
          seg_dur  = cfg.element_gap;
          if (elem + ELEM_W'(1) == cur.code.len) begin
            state_next = BK_LETTER;
          end else begin
            elem_next  = elem + ELEM_W'(1);
            state_next = BK_ON;
          end
        end
      end
      BK_LETTER: begin
        if (load) begin
          seg_load = 1'b1;
          seg_dur  = cfg.letter_gap;
          seg_last = 1'b1;
          fetch    = 1'b1;
        end
      end
      BK_WORD: begin
        if (load) begin
          seg_load = 1'b1;
          seg_dur  = cfg.word_gap;
          seg_last = 1'b1;
          fetch    = 1'b1;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase

    // the next character is taken from idle, or in the same cycle as the closing segment
    if (fetch) begin
      if (q_valid) begin
        q_pop     = 1'b1;
        cur_next  = q_data;
        elem_next = '0;
        unique case (q_data.kind)
          KIND_CHAR:  state_next = BK_ON;
          KIND_SPACE: state_next = BK_WORD;
          default:    state_next = BK_LETTER;
        endcase
      end else begin
        state_next = BK_IDLE;
      end
    end
  end

  `MCKU_ASSERT_IMP(a_pop_needs_data, q_pop, q_valid, "pop from empty queue")
  `MCKU_ASSERT_IMP(a_elem_in_range, state == BK_ON || state == BK_GAP, elem < cur.code.len && cur.kind == KIND_CHAR, "element index past pattern")
  `MCKU_ASSERT_IMP(a_on_not_last, out_valid && led_level, !last_segment, "on segment marked last")
  `MCKU_ASSERT_IMP(a_load_when_free, seg_load, !out_valid || out_ready, "output overwritten")

endmodule

FILE: src/morse_code_keyer_unit.sv
// top level of the morse code keyer: configuration registers, front end,
// descriptor queue and segment sequencer; depends on mck_pkg and the mck_* modules
//
// usage:
//   input channel  in_valid / in_ready with char_code, one ascii character per transfer
//   output channel out_valid / out_ready with led_level, duration_ms, last_segment,
//     one led segment per transfer; last_segment marks the final one of a character
//   config port    cfg_we / cfg_index / cfg_data, no read-back:
//     0 dot on, 1 dash on, 2 element gap, 3 letter gap, 4 word gap; others ignored
// timing:
//   a character with n elements gives 2n+1 segments, a space or unknown code one;
//   the sequencer issues one segment a cycle into the output register while
//   out_ready stays high
//   from idle, a character passes the front stage, the queue and the sequencer to the output register
//   a two-entry queue and a front stage let characters be taken while segments drain
// reset: rst is synchronous; it empties the queue and output and restores the
//   default durations 200, 600, 200, 600, 1400 ms
// stall: with out_ready low the segment holds, the sequencer waits, and in_ready
//   drops once the front stage and the queue are full
module morse_code_keyer_unit import mck_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           char_code,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 led_level,
  output logic [DUR_W-1:0]     duration_ms,
  output logic                 last_segment,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_data
);

  cfg_regs_t cfg;
  logic      push;
  desc_t     push_data;
  logic      push_ready;
  logic      q_pop;
  logic      q_valid;
  desc_t     q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot_on      <= DOT_ON_RESET;
      cfg.dash_on     <= DASH_ON_RESET;
      cfg.element_gap <= ELEMENT_GAP_RESET;
      cfg.letter_gap  <= LETTER_GAP_RESET;
      cfg.word_gap    <= WORD_GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DOT_ON:      cfg.dot_on      <= cfg_data;
        REG_DASH_ON:     cfg.dash_on     <= cfg_data;
        REG_ELEMENT_GAP: cfg.element_gap <= cfg_data;
        REG_LETTER_GAP:  cfg.letter_gap  <= cfg_data;
        REG_WORD_GAP:    cfg.word_gap    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mck_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  mck_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  mck_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .led_level    (led_level),
    .duration_ms  (duration_ms),
    .last_segment (last_segment)
  );

endmodule
